/* sv/sos_pkg.sv */
// sweep object segmenter: shared constants, types and the tangent table
// used by sos_track, sos_width and sweep_object_segmenter_top; no dependencies
package sos_pkg;

	localparam int DIST_BITS   = 12;
	localparam int ANGLE_W     = 8;
	localparam int WIDTH_W     = 19;
	localparam int INDEX_W     = 8;
	localparam int CFG_W       = (DIST_BITS > ANGLE_W) ? DIST_BITS : ANGLE_W;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_W        = DIST_BITS + ANGLE_W;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = 2 * ANGLE_W + DIST_BITS + WIDTH_W + INDEX_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int TAN_W       = 22;
	localparam int TAN_ENTRIES = 90;
	localparam int HALF_W      = ANGLE_W - 1;
	localparam int TAN_FRAC    = 16;

	localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;
	localparam logic [INDEX_W-1:0] INDEX_MAX = '1;
	localparam logic [DIST_BITS-1:0] NEAR_THRESHOLD_RST = DIST_BITS'(80);
	localparam logic [ANGLE_W-1:0] END_ANGLE_RST = ANGLE_W'(180);
	localparam logic [HALF_W-1:0] HALF_LIMIT = HALF_W'(TAN_ENTRIES);

	localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_END_ANGLE      = CFG_IDX_W'(1);

	// tan(k deg) in unsigned q6.16, rounded to nearest
	localparam logic [TAN_W-1:0] TAN_Q16 [TAN_ENTRIES] = '{
		22'd0, 22'd1144, 22'd2289, 22'd3435, 22'd4583, 22'd5734, 22'd6888, 22'd8047,
		22'd9210, 22'd10380, 22'd11556, 22'd12739, 22'd13930, 22'd15130, 22'd16340,
		22'd17560, 22'd18792, 22'd20036, 22'd21294, 22'd22566, 22'd23853, 22'd25157,
		22'd26478, 22'd27818, 22'd29179, 22'd30560, 22'd31964, 22'd33392, 22'd34846,
		22'd36327, 22'd37837, 22'd39378, 22'd40951, 22'd42560, 22'd44205, 22'd45889,
		22'd47615, 22'd49385, 22'd51202, 22'd53070, 22'd54991, 22'd56970, 22'd59009,
		22'd61113, 22'd63287, 22'd65536, 22'd67865, 22'd70279, 22'd72785, 22'd75391,
		22'd78103, 22'd80930, 22'd83882, 22'd86969, 22'd90203, 22'd93595, 22'd97161,
		22'd100917, 22'd104880, 22'd109070, 22'd113512, 22'd118230, 22'd123255,
		22'd128622, 22'd134369, 22'd140542, 22'd147196, 22'd154393, 22'd162207,
		22'd170727, 22'd180059, 22'd190330, 22'd201699, 22'd214359, 22'd228551,
		22'd244584, 22'd262851, 22'd283868, 22'd308323, 22'd337153, 22'd371673,
		22'd413778, 22'd466313, 22'd533748, 22'd623533, 22'd749080, 22'd937208,
		22'd1250501, 22'd1876706, 22'd3754555
	};

	typedef struct packed {
		logic [ANGLE_W-1:0]   obj_start;
		logic [ANGLE_W-1:0]   obj_end;
		logic [DIST_BITS-1:0] obj_dist;
		logic [INDEX_W-1:0]   obj_index;
	} obj_t;

endpackage

/* sv/sos_track.sv */
// sweep object segmenter: config registers, segment state and close detection
// depends on sos_pkg; feeds a closed object into a one-entry stage register
module sos_track (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sos_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sos_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sos_pkg::DIST_BITS-1:0]  in_distance,
	input  logic [sos_pkg::ANGLE_W-1:0]    in_angle,
	input  logic                           in_sweep_start,
	output logic                           obj_valid,
	input  logic                           obj_ready,
	output sos_pkg::obj_t                  obj
);
	import sos_pkg::*;

	logic [DIST_BITS-1:0] near_threshold_q;
	logic [ANGLE_W-1:0]   end_angle_q;
	logic                 in_object_q;
	logic [ANGLE_W-1:0]   open_start_angle_q;
	logic [DIST_BITS-1:0] previous_distance_q;
	logic [INDEX_W-1:0]   objects_found_q;
	logic                 valid_s1;
	obj_t                 obj_s1;
	logic                 accept;
	logic                 is_near;
	logic                 do_open;
	logic                 do_close;
	logic                 s1_ready;

	assign s1_ready = !valid_s1 || obj_ready;
	assign in_ready = s1_ready;
	assign accept   = in_valid && s1_ready;
	assign is_near  = in_distance < near_threshold_q;
	assign do_open  = !in_sweep_start && !in_object_q && is_near;
	assign do_close = !in_sweep_start && in_object_q && (!is_near || in_angle == end_angle_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_threshold_q <= NEAR_THRESHOLD_RST;
			end_angle_q      <= END_ANGLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEAR_THRESHOLD: near_threshold_q <= cfg_wdata[DIST_BITS-1:0];
				REG_END_ANGLE:      end_angle_q      <= cfg_wdata[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_object_q         <= 1'b0;
			open_start_angle_q  <= '0;
			previous_distance_q <= '0;
			objects_found_q     <= '0;
		end else if (accept) begin
			previous_distance_q <= in_distance;
			if (in_sweep_start) begin
				in_object_q     <= 1'b0;
				objects_found_q <= '0;
			end else if (do_open) begin
				in_object_q        <= 1'b1;
				open_start_angle_q <= in_angle;
			end else if (do_close) begin
				in_object_q <= 1'b0;
				if (objects_found_q != INDEX_MAX) begin
					objects_found_q <= objects_found_q + INDEX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= accept && do_close;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && do_close) begin
			obj_s1.obj_start <= open_start_angle_q;
			obj_s1.obj_end   <= in_angle;
			obj_s1.obj_dist  <= previous_distance_q;
			obj_s1.obj_index <= objects_found_q;
		end
	end

	assign obj_valid = valid_s1;
	assign obj       = obj_s1;

	a_sweep_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_sweep_start |=> !in_object_q && objects_found_q == '0)
		else $error("sweep start did not clear segment state");

	a_close_ends_object: assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_close |=> !in_object_q && valid_s1)
		else $error("closing beat did not leave a closed object");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_sweep_start |=> objects_found_q >= $past(objects_found_q))
		else $error("object count decreased within a sweep");

	a_open_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_open && s1_ready |=> !valid_s1)
		else $error("opening beat produced a result");

endmodule

/* sv/sos_width.sv */
// sweep object segmenter: width estimate from tangent table and one multiply,
// result register with handshake; depends on sos_pkg
module sos_width (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          obj_valid,
	output logic                          obj_ready,
	input  sos_pkg::obj_t                 obj,
	output logic                          res_valid,
	input  logic                          res_ready,
	output sos_pkg::obj_t                 res_obj,
	output logic [sos_pkg::WIDTH_W-1:0]   res_width
);
	import sos_pkg::*;

	localparam int PROD_W = DIST_BITS + TAN_W;

	logic                 valid_q;
	obj_t                 obj_q;
	logic [WIDTH_W-1:0]   width_q;
	logic                 out_ready;
	logic                 reversed;
	logic [ANGLE_W-1:0]   span;
	logic [HALF_W-1:0]    half;
	logic                 half_big;
	logic [HALF_W-1:0]    tan_idx;
	logic [TAN_W-1:0]     tan_val;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-1:0]    prod_sh;
	logic [WIDTH_W-1:0]   width;

	assign out_ready = !valid_q || res_ready;
	assign obj_ready = out_ready;

	assign reversed = obj.obj_end < obj.obj_start;
	assign span     = obj.obj_end - obj.obj_start;
	assign half     = span[ANGLE_W-1:1];
	assign half_big = half >= HALF_LIMIT;
	assign tan_idx  = half_big ? '0 : half;
	assign tan_val  = TAN_Q16[tan_idx];
	assign prod     = PROD_W'(obj.obj_dist) * PROD_W'(tan_val);
	// times two, then drop the q16 fraction
	assign prod_sh  = prod >> (TAN_FRAC - 1);

	always_comb begin
		if (reversed || obj.obj_dist == '0) begin
			width = '0;
		end else if (half_big || prod_sh > PROD_W'(WIDTH_MAX)) begin
			width = WIDTH_MAX;
		end else begin
			width = prod_sh[WIDTH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= obj_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (obj_valid && out_ready) begin
			obj_q   <= obj;
			width_q <= width;
		end
	end

	assign res_valid = valid_q;
	assign res_obj   = obj_q;
	assign res_width = width_q;

	a_reversed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && obj_q.obj_end < obj_q.obj_start |-> width_q == '0)
		else $error("reversed object has nonzero width");

	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && obj_q.obj_dist == '0 |-> width_q == '0)
		else $error("zero distance object has nonzero width");

	a_wide_span_sat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && obj_q.obj_end >= obj_q.obj_start && obj_q.obj_dist != '0
		&& ((obj_q.obj_end - obj_q.obj_start) >> 1) >= ANGLE_W'(TAN_ENTRIES)
		|-> width_q == WIDTH_MAX)
		else $error("wide span did not saturate width");

endmodule

/* sv/sweep_object_segmenter_top.sv */
// sweep object segmenter top level: stream ports and config write port
// depends on sos_pkg, sos_track and sos_width
//
// usage: one range reading enters per s_ beat (distance and angle in s_tdata,
// sweep start flag in s_tuser). a reading that closes an open object yields
// one m_ beat carrying start, end, distance, width and index; other readings
// yield nothing. config registers are written through cfg_we / cfg_index /
// cfg_wdata (0: near threshold, 1: end angle); the user must write them only
// while the block is idle, which the block does not enforce. throughput: one
// reading per cycle while s_tready is high. a closing reading passes the close
// detect register, then the width multiply into the result register that drives m_tvalid.
// reset clears the segment state and count, and loads near threshold 80 and
// end angle 180; both result stages come out empty.
// when m_tready is low the result register holds; the close stage still takes
// one more object, and s_tready drops only once both stages are full.
// readings keep flowing while a result waits as long as the close stage is empty.
module sweep_object_segmenter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sos_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sos_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// distance, angle, zero pad
	input  logic [sos_pkg::IN_TDATA_W-1:0]   s_tdata,
	// sweep_start
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// object_start, object_end, object_distance, object_width, object_index, zero pad
	output logic [sos_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import sos_pkg::*;

	logic                 obj_valid;
	logic                 obj_ready;
	obj_t                 obj;
	obj_t                 res_obj;
	logic [WIDTH_W-1:0]   res_width;
	logic [OUT_W-1:0]     res_packed;

	sos_track u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_distance    (s_tdata[DIST_BITS-1:0]),
		.in_angle       (s_tdata[IN_W-1:DIST_BITS]),
		.in_sweep_start (s_tuser),
		.obj_valid      (obj_valid),
		.obj_ready      (obj_ready),
		.obj            (obj)
	);

	sos_width u_width (
		.clk       (clk),
		.arst_n    (arst_n),
		.obj_valid (obj_valid),
		.obj_ready (obj_ready),
		.obj       (obj),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_obj   (res_obj),
		.res_width (res_width)
	);

	assign res_packed = {res_obj.obj_index, res_width, res_obj.obj_dist,
		res_obj.obj_end, res_obj.obj_start};
	assign m_tdata = OUT_TDATA_W'(res_packed);

endmodule
